[rtl/v86_sensitive_instruction_monitor_defines.svh]
// Assertion macros used by the monitor's port-level checker file.
// Depends on nothing; include by bare file name.
`ifndef V86_SENSITIVE_INSTRUCTION_MONITOR_DEFINES_SVH
`define V86_SENSITIVE_INSTRUCTION_MONITOR_DEFINES_SVH

// Assertion that is switched off while reset is high.
`define V86SIM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked at every clock edge, reset included.
`define V86SIM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/v86sim_pkg.sv]
// Package for the virtual-8086 instruction monitor: opcodes, result codes and
// the packed layouts of request and response data. Depends on nothing.
`default_nettype none

package v86sim_pkg;

   localparam int REQ_DATA_W = 264;
   localparam int RSP_DATA_W = 216;

   localparam logic [7:0] OP_OPSIZE   = 8'h66;
   localparam logic [7:0] OP_ADDRSIZE = 8'h67;
   localparam logic [7:0] OP_PUSHF    = 8'h9C;
   localparam logic [7:0] OP_POPF     = 8'h9D;
   localparam logic [7:0] OP_OUT_W    = 8'hEF;
   localparam logic [7:0] OP_OUT_B    = 8'hEE;
   localparam logic [7:0] OP_IN_W     = 8'hED;
   localparam logic [7:0] OP_IN_B     = 8'hEC;
   localparam logic [7:0] OP_INT      = 8'hCD;
   localparam logic [7:0] OP_IRET     = 8'hCF;
   localparam logic [7:0] OP_CLI      = 8'hFA;
   localparam logic [7:0] OP_STI      = 8'hFB;
   localparam logic [7:0] OP_HLT      = 8'hF4;

   localparam logic [7:0] VEC_SKIP     = 8'h30;
   localparam logic [7:0] VEC_KERNEL_A = 8'h20;
   localparam logic [7:0] VEC_KERNEL_B = 8'h21;

   localparam logic [1:0] IO_NONE = 2'd0;
   localparam logic [1:0] IO_IN   = 2'd1;
   localparam logic [1:0] IO_OUT  = 2'd2;

   localparam logic [1:0] IO_BYTE  = 2'd0;
   localparam logic [1:0] IO_WORD  = 2'd1;
   localparam logic [1:0] IO_DWORD = 2'd2;

   localparam logic [1:0] RES_HANDLED   = 2'd0;
   localparam logic [1:0] RES_KERNEL    = 2'd1;
   localparam logic [1:0] RES_HALT      = 2'd2;
   localparam logic [1:0] RES_UNHANDLED = 2'd3;

   localparam int          FLAG_IF_BIT       = 9;
   localparam logic [31:0] FLAG_IF           = 32'h0000_0200;
   localparam logic [31:0] FLAG_VM           = 32'h0002_0000;
   localparam logic [31:0] VALID_FLAGS_RESET = 32'h0000_0DFF;

   // First field in the highest bits.
   typedef struct packed {
      logic [31:0] io_read_data;
      logic [31:0] vector_entry;
      logic [47:0] stack_window;
      logic [15:0] port_in;
      logic [31:0] acc_in;
      logic [31:0] flags_in;
      logic [15:0] sp_in;
      logic [15:0] cs_in;
      logic [15:0] ip_in;
      logic [23:0] code_bytes;
   } req_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [31:0] io_write_data;
      logic [15:0] io_port;
      logic [1:0]  io_width;
      logic [1:0]  io_kind;
      logic [1:0]  push_words;
      logic [47:0] push_data;
      logic [31:0] acc_out;
      logic [31:0] flags_out;
      logic [15:0] sp_out;
      logic [15:0] cs_out;
      logic [15:0] ip_out;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/v86_sensitive_instruction_monitor.sv]
// A request passes through the request register, then the response register,
// before its response is valid and can transfer.
// Throughput: one item per cycle; the input stalls only while both registers
// are full and the response is held off. The configuration port is always ready.
// Reset (synchronous, active high) empties both registers, clears the
// virtual interrupt flag and loads the flags mask with 0x00000DFF.
`default_nettype none

module v86_sensitive_instruction_monitor (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [31:0]                           csr_data,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // code_bytes, ip_in, cs_in, sp_in, flags_in, acc_in, port_in,
   // stack_window, vector_entry, io_read_data
   input  wire  [v86sim_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // ip_out, cs_out, sp_out, flags_out, acc_out, push_data, push_words,
   // io_kind, io_width, io_port, io_write_data, outcome
   output logic [v86sim_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import v86sim_pkg::*;

   logic        req_valid_ff, req_valid_in;
   req_type     req_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        vif_ff, vif_in, vif_next;
   logic [31:0] mask_ff;

   logic        out_load, req_transfer, advance;
   logic        prefix, op32;
   logic [7:0]  op, imm;
   logic [15:0] ip_base, ip_next1, ip_next2;
   logic [15:0] w0, w1, w2;
   logic [31:0] dword, push32, push16;

   assign csr_ready    = 1'b1;
   assign out_load     = !rsp_valid_ff || rsp_tready;
   assign req_tready   = !req_valid_ff || out_load;
   assign req_transfer = req_tvalid && req_tready;
   assign advance      = req_valid_ff && out_load;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_ff;

   always_comb begin
      req_valid_in = req_transfer ? 1'b1 : (out_load ? 1'b0 : req_valid_ff);
      rsp_valid_in = out_load ? req_valid_ff : rsp_valid_ff;
      vif_in       = advance ? vif_next : vif_ff;
   end

   always_comb begin
      prefix   = (req_ff.code_bytes[7:0] == OP_OPSIZE) ||
                 (req_ff.code_bytes[7:0] == OP_ADDRSIZE);
      op32     = (req_ff.code_bytes[7:0] == OP_OPSIZE);
      op       = prefix ? req_ff.code_bytes[15:8] : req_ff.code_bytes[7:0];
      imm      = prefix ? req_ff.code_bytes[23:16] : req_ff.code_bytes[15:8];
      ip_base  = req_ff.ip_in + {15'd0, prefix};
      ip_next1 = ip_base + 16'd1;
      ip_next2 = ip_base + 16'd2;
      w0       = req_ff.stack_window[15:0];
      w1       = req_ff.stack_window[31:16];
      w2       = req_ff.stack_window[47:32];
      dword    = {w1, w0};

      push32              = req_ff.flags_in & mask_ff;
      push32[FLAG_IF_BIT] = vif_ff;
      push16              = {16'd0, req_ff.flags_in[15:0]};
      push16[FLAG_IF_BIT] = vif_ff;

      rsp_in.ip_out        = ip_next1;
      rsp_in.cs_out        = req_ff.cs_in;
      rsp_in.sp_out        = req_ff.sp_in;
      rsp_in.flags_out     = req_ff.flags_in;
      rsp_in.acc_out       = req_ff.acc_in;
      rsp_in.push_data     = '0;
      rsp_in.push_words    = 2'd0;
      rsp_in.io_kind       = IO_NONE;
      rsp_in.io_width      = IO_BYTE;
      rsp_in.io_port       = '0;
      rsp_in.io_write_data = '0;
      rsp_in.outcome       = RES_HANDLED;
      vif_next             = vif_ff;

      unique case (op)
         OP_PUSHF: begin
            if (op32) begin
               rsp_in.sp_out     = req_ff.sp_in - 16'd4;
               rsp_in.push_data  = {16'd0, push32};
               rsp_in.push_words = 2'd2;
            end else begin
               rsp_in.sp_out     = req_ff.sp_in - 16'd2;
               rsp_in.push_data  = {16'd0, push16};
               rsp_in.push_words = 2'd1;
            end
         end
         OP_POPF: begin
            if (op32) begin
               rsp_in.flags_out = FLAG_IF | FLAG_VM | (dword & mask_ff);
               rsp_in.sp_out    = req_ff.sp_in + 16'd4;
            end else begin
               rsp_in.flags_out = FLAG_IF | FLAG_VM | {16'd0, w0};
               rsp_in.sp_out    = req_ff.sp_in + 16'd2;
            end
            vif_next = w0[FLAG_IF_BIT];
         end
         OP_OUT_W: begin
            rsp_in.io_kind       = IO_OUT;
            rsp_in.io_port       = req_ff.port_in;
            rsp_in.io_width      = op32 ? IO_DWORD : IO_WORD;
            rsp_in.io_write_data = op32 ? req_ff.acc_in : {16'd0, req_ff.acc_in[15:0]};
         end
         OP_OUT_B: begin
            rsp_in.io_kind       = IO_OUT;
            rsp_in.io_port       = req_ff.port_in;
            rsp_in.io_write_data = {24'd0, req_ff.acc_in[7:0]};
         end
         OP_IN_W: begin
            rsp_in.io_kind = IO_IN;
            rsp_in.io_port = req_ff.port_in;
            if (op32) begin
               rsp_in.io_width = IO_DWORD;
               rsp_in.acc_out  = req_ff.io_read_data;
            end else begin
               rsp_in.io_width = IO_WORD;
               rsp_in.acc_out  = {req_ff.acc_in[31:16], req_ff.io_read_data[15:0]};
            end
         end
         OP_IN_B: begin
            rsp_in.io_kind = IO_IN;
            rsp_in.io_port = req_ff.port_in;
            rsp_in.acc_out = {req_ff.acc_in[31:8], req_ff.io_read_data[7:0]};
         end
         OP_INT: begin
            rsp_in.ip_out = ip_next2;
            if (imm == VEC_KERNEL_A || imm == VEC_KERNEL_B) begin
               rsp_in.outcome = RES_KERNEL;
            end else if (imm != VEC_SKIP) begin
               rsp_in.sp_out     = req_ff.sp_in - 16'd6;
               rsp_in.push_data  = {ip_next2, req_ff.cs_in, push16[15:0]};
               rsp_in.push_words = 2'd3;
               rsp_in.ip_out     = req_ff.vector_entry[15:0];
               rsp_in.cs_out     = req_ff.vector_entry[31:16];
            end
         end
         OP_IRET: begin
            rsp_in.ip_out    = w2;
            rsp_in.cs_out    = w1;
            rsp_in.flags_out = FLAG_IF | FLAG_VM | {16'd0, w0};
            rsp_in.sp_out    = req_ff.sp_in + 16'd6;
            vif_next         = w0[FLAG_IF_BIT];
         end
         OP_CLI: begin
            vif_next = 1'b0;
         end
         OP_STI: begin
            vif_next = 1'b1;
         end
         OP_HLT: begin
            rsp_in.ip_out  = ip_base;
            rsp_in.outcome = RES_HALT;
         end
         default: begin
            rsp_in.outcome = RES_UNHANDLED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vif_ff       <= 1'b0;
         mask_ff      <= VALID_FLAGS_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         vif_ff       <= vif_in;
         if (csr_valid && csr_ready) begin
            mask_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         req_ff <= req_type'(req_tdata);
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

[rtl/v86sim_checker.sv]
// Port-level checker for the virtual-8086 instruction monitor, bound to the top.
// Depends on v86sim_pkg and v86_sensitive_instruction_monitor_defines.svh.
`default_nettype none
`include "v86_sensitive_instruction_monitor_defines.svh"

module v86sim_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                rsp_tvalid,
   input wire                                rsp_tready,
   input wire [v86sim_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import v86sim_pkg::*;

   rsp_type rsp;
   logic    stalled;
   logic    io_fields_ok;
   logic    push_fields_ok;

   assign rsp            = rsp_type'(rsp_tdata);
   assign stalled        = rsp_tvalid && !rsp_tready;
   assign io_fields_ok   = (rsp.io_kind != IO_NONE) ||
                           (rsp.io_width == IO_BYTE && rsp.io_port == 16'd0 &&
                            rsp.io_write_data == 32'd0);
   assign push_fields_ok = (rsp.push_words != 2'd0 || rsp.push_data == 48'd0) &&
                           (rsp.io_kind inside {IO_NONE, IO_IN, IO_OUT}) &&
                           (rsp.io_kind != IO_IN || rsp.io_write_data == 32'd0);

   `V86SIM_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_tvalid,
      "response valid after reset")
   `V86SIM_ASSERT(a_stall_holds, clock, reset,
      stalled |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `V86SIM_ASSERT(a_io_idle_zero, clock, reset, rsp_tvalid |-> io_fields_ok,
      "port fields set without access")
   `V86SIM_ASSERT(a_push_consistent, clock, reset, rsp_tvalid |-> push_fields_ok,
      "inconsistent push or port fields")

endmodule

bind v86_sensitive_instruction_monitor v86sim_checker u_v86sim_checker (.*);

`default_nettype wire

[bench/v86_emulation_checker.sv]
// Checker for the virtual-8086 instruction monitor: watches the CSR, request and
// response channels, emulates each trapped instruction and compares responses.
// Depends on v86sim_pkg for the opcode constants and the packed data layouts.
`timescale 1ns / 1ps

module v86_emulation_checker (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_valid,
   input  wire                               csr_ready,
   input  wire  [31:0]                       csr_data,
   input  wire                               req_tvalid,
   input  wire                               req_tready,
   input  wire  [v86sim_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire                               rsp_tvalid,
   input  wire                               rsp_tready,
   input  wire  [v86sim_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                                error_count,
   output int                                pending
);
   import v86sim_pkg::*;

   logic [31:0] shadow_mask = VALID_FLAGS_RESET;
   logic        shadow_vif = 1'b0;
   rsp_type     emulated_results[$];

   function automatic rsp_type emulate_trap(input req_type t);
      rsp_type     o;
      logic        op32;
      logic [7:0]  opc;
      logic [7:0]  imm;
      logic [15:0] w0;
      logic [15:0] w1;
      logic [15:0] w2;
      logic [15:0] ret;
      logic [31:0] word32;
      o = '0;
      o.ip_out = t.ip_in;
      o.cs_out = t.cs_in;
      o.sp_out = t.sp_in;
      o.flags_out = t.flags_in;
      o.acc_out = t.acc_in;
      o.io_kind = IO_NONE;
      o.io_width = IO_BYTE;
      o.outcome = RES_HANDLED;
      {w2, w1, w0} = t.stack_window;
      op32 = 1'b0;
      opc = t.code_bytes[7:0];
      imm = t.code_bytes[15:8];
      if (opc == OP_OPSIZE || opc == OP_ADDRSIZE) begin
         op32 = (opc == OP_OPSIZE);
         o.ip_out = o.ip_out + 16'd1;
         opc = t.code_bytes[15:8];
         imm = t.code_bytes[23:16];
      end
      case (opc)
         OP_PUSHF: begin
            if (op32) begin
               word32 = t.flags_in & shadow_mask;
               o.sp_out = o.sp_out - 16'd4;
               o.push_words = 2'd2;
            end else begin
               word32 = {16'h0000, t.flags_in[15:0]};
               o.sp_out = o.sp_out - 16'd2;
               o.push_words = 2'd1;
            end
            word32[FLAG_IF_BIT] = shadow_vif;
            o.push_data = {16'h0000, word32};
            o.ip_out = o.ip_out + 16'd1;
         end
         OP_POPF: begin
            if (op32) begin
               word32 = {w1, w0} & shadow_mask;
               o.sp_out = o.sp_out + 16'd4;
            end else begin
               word32 = {16'h0000, w0};
               o.sp_out = o.sp_out + 16'd2;
            end
            o.flags_out = word32 | FLAG_IF | FLAG_VM;
            shadow_vif = w0[FLAG_IF_BIT];
            o.ip_out = o.ip_out + 16'd1;
         end
         OP_OUT_W: begin
            o.io_kind = IO_OUT;
            o.io_port = t.port_in;
            o.io_width = op32 ? IO_DWORD : IO_WORD;
            o.io_write_data = op32 ? t.acc_in : {16'h0000, t.acc_in[15:0]};
            o.ip_out = o.ip_out + 16'd1;
         end
         OP_OUT_B: begin
            o.io_kind = IO_OUT;
            o.io_port = t.port_in;
            o.io_width = IO_BYTE;
            o.io_write_data = {24'h000000, t.acc_in[7:0]};
            o.ip_out = o.ip_out + 16'd1;
         end
         OP_IN_W: begin
            o.io_kind = IO_IN;
            o.io_port = t.port_in;
            if (op32) begin
               o.io_width = IO_DWORD;
               o.acc_out = t.io_read_data;
            end else begin
               o.io_width = IO_WORD;
               o.acc_out = {t.acc_in[31:16], t.io_read_data[15:0]};
            end
            o.ip_out = o.ip_out + 16'd1;
         end
         OP_IN_B: begin
            o.io_kind = IO_IN;
            o.io_port = t.port_in;
            o.io_width = IO_BYTE;
            o.acc_out = {t.acc_in[31:8], t.io_read_data[7:0]};
            o.ip_out = o.ip_out + 16'd1;
         end
         OP_INT: begin
            if (imm == VEC_SKIP) begin
               o.ip_out = o.ip_out + 16'd2;
            end else if (imm == VEC_KERNEL_A || imm == VEC_KERNEL_B) begin
               o.ip_out = o.ip_out + 16'd2;
               o.outcome = RES_KERNEL;
            end else begin
               ret = o.ip_out + 16'd2;
               word32 = {16'h0000, t.flags_in[15:0]};
               word32[FLAG_IF_BIT] = shadow_vif;
               o.sp_out = o.sp_out - 16'd6;
               o.push_data = {ret, t.cs_in, word32[15:0]};
               o.push_words = 2'd3;
               o.ip_out = t.vector_entry[15:0];
               o.cs_out = t.vector_entry[31:16];
            end
         end
         OP_IRET: begin
            o.ip_out = w2;
            o.cs_out = w1;
            o.flags_out = FLAG_IF | FLAG_VM | {16'h0000, w0};
            o.sp_out = o.sp_out + 16'd6;
            shadow_vif = w0[FLAG_IF_BIT];
         end
         OP_CLI: begin
            shadow_vif = 1'b0;
            o.ip_out = o.ip_out + 16'd1;
         end
         OP_STI: begin
            shadow_vif = 1'b1;
            o.ip_out = o.ip_out + 16'd1;
         end
         OP_HLT: begin
            o.outcome = RES_HALT;
         end
         default: begin
            o.ip_out = o.ip_out + 16'd1;
            o.outcome = RES_UNHANDLED;
         end
      endcase
      return o;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   task automatic compare_result(input rsp_type want, input rsp_type got);
      check_field("ip_out", want.ip_out, got.ip_out);
      check_field("cs_out", want.cs_out, got.cs_out);
      check_field("sp_out", want.sp_out, got.sp_out);
      check_field("flags_out", want.flags_out, got.flags_out);
      check_field("acc_out", want.acc_out, got.acc_out);
      check_field("push_data", want.push_data, got.push_data);
      check_field("push_words", want.push_words, got.push_words);
      check_field("io_kind", want.io_kind, got.io_kind);
      check_field("io_width", want.io_width, got.io_width);
      check_field("io_port", want.io_port, got.io_port);
      check_field("io_write_data", want.io_write_data, got.io_write_data);
      check_field("outcome", want.outcome, got.outcome);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_mask = VALID_FLAGS_RESET;
         shadow_vif = 1'b0;
         emulated_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            shadow_mask = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (emulated_results.size() == 0) begin
               $error("response transfer with no instruction outstanding");
               error_count++;
            end else begin
               compare_result(emulated_results.pop_front(), rsp_tdata);
            end
         end
         if (req_tvalid && req_tready) begin
            emulated_results.push_back(emulate_trap(req_tdata));
         end
      end
      pending = emulated_results.size();
   end

endmodule

[bench/tb_top.sv]
// Top of the testbench for the virtual-8086 instruction monitor: clock, reset,
// stimulus, response back-pressure and the verdict.
// Depends on v86sim_pkg, the monitor RTL and v86_emulation_checker.
`timescale 1ns / 1ps

module tb_top;
   import v86sim_pkg::*;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int BATCH_ITEMS = 270;
   localparam logic [7:0] OP_UNKNOWN = 8'h90;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [31:0]           csr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int   error_count;
   int   pending;
   int   idle_cycles = 0;
   bit   sender_gaps = 1'b0;
   bit   receiver_gaps = 1'b0;
   bit   hold_off_req = 1'b0;
   bit   extreme_hi = 1'b1;

   always #1 clock = ~clock;

   v86_sensitive_instruction_monitor u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   v86_emulation_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (error_count),
      .pending     (pending)
   );

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] pick_word();
      logic [31:0] rnd;
      rnd = $urandom;
      if (rnd[31:29] != 3'd0) return rnd[15:0];
      case (rnd[17:16])
         2'd0: return 16'h0000;
         2'd1: return 16'h0001;
         2'd2: return 16'hFFFE;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic req_type random_trap();
      req_type     t;
      logic [31:0] rnd;
      logic [7:0]  op;
      logic [7:0]  imm;
      logic [7:0]  pfx;
      bit          has_pfx;
      t.ip_in = pick_word();
      t.sp_in = pick_word();
      rnd = $urandom;
      t.cs_in = rnd[15:0];
      t.port_in = rnd[31:16];
      t.flags_in = $urandom;
      t.acc_in = $urandom;
      t.vector_entry = $urandom;
      t.io_read_data = $urandom;
      t.stack_window[31:0] = $urandom;
      rnd = $urandom;
      t.stack_window[47:32] = rnd[15:0];
      rnd = $urandom;
      case ($urandom_range(0, 12))
         0: op = OP_PUSHF;
         1: op = OP_POPF;
         2: op = OP_OUT_W;
         3: op = OP_OUT_B;
         4: op = OP_IN_W;
         5: op = OP_IN_B;
         6: op = OP_INT;
         7: op = OP_IRET;
         8: op = OP_CLI;
         9: op = OP_STI;
         10: op = OP_HLT;
         11: op = rnd[7:0];
         default: op = OP_OPSIZE;
      endcase
      case ($urandom_range(0, 4))
         0: imm = VEC_SKIP;
         1: imm = VEC_KERNEL_A;
         2: imm = VEC_KERNEL_B;
         default: imm = rnd[15:8];
      endcase
      has_pfx = 1'b1;
      case ($urandom_range(0, 5))
         0, 1: pfx = OP_OPSIZE;
         2: pfx = OP_ADDRSIZE;
         default: begin
            pfx = OP_OPSIZE;
            has_pfx = 1'b0;
         end
      endcase
      t.code_bytes = has_pfx ? {imm, op, pfx} : {rnd[23:16], imm, op};
      return t;
   endfunction

   task automatic send_trap(input req_type t);
      int g;
      req_tvalid <= 1'b1;
      req_tdata <= t;
      do @(posedge clock); while (!req_tready);
      g = sender_gaps ? idle_gap() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send_directed(input bit has_pfx, input logic [7:0] pfx,
                                input logic [7:0] op, input logic [7:0] imm);
      req_type t;
      t = random_trap();
      t.code_bytes = has_pfx ? {imm, op, pfx} : {t.code_bytes[23:16], imm, op};
      if (extreme_hi) begin
         t.ip_in = 16'hFFFF;
         t.cs_in = 16'hFFFF;
         t.sp_in = 16'h0000;
         t.flags_in = 32'hFFFF_FFFF;
         t.acc_in = 32'hFFFF_FFFF;
         t.port_in = 16'hFFFF;
         t.stack_window = 48'hFFFF_FFFF_FFFF;
         t.vector_entry = 32'hFFFF_FFFF;
         t.io_read_data = 32'hFFFF_FFFF;
      end else begin
         t.ip_in = 16'h0000;
         t.cs_in = 16'h0000;
         t.sp_in = 16'hFFFF;
         t.flags_in = '0;
         t.acc_in = '0;
         t.port_in = 16'h0000;
         t.stack_window = '0;
         t.vector_entry = '0;
         t.io_read_data = '0;
      end
      extreme_hi = !extreme_hi;
      send_trap(t);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_flags_mask(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_batch(input int count, input bit tx_gaps, input bit rx_gaps,
                            input bit long_hold);
      sender_gaps = tx_gaps;
      receiver_gaps = rx_gaps;
      for (int n = 0; n < count; n++) begin
         if (long_hold && n == count / 3) hold_off_req = 1'b1;
         send_trap(random_trap());
      end
      wait_drained();
   endtask

   initial begin : response_side
      int g;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
            g = 1 + idle_gap();
            rsp_tready <= 1'b0;
            repeat (g) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [31:0] rnd;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_directed(1'b0, OP_OPSIZE, OP_PUSHF, 8'h00);
      send_directed(1'b1, OP_OPSIZE, OP_PUSHF, 8'h00);
      send_directed(1'b0, OP_OPSIZE, OP_STI, 8'h00);
      send_directed(1'b0, OP_OPSIZE, OP_PUSHF, 8'h00);
      send_directed(1'b0, OP_OPSIZE, OP_POPF, 8'h00);
      send_directed(1'b1, OP_OPSIZE, OP_POPF, 8'h00);
      send_directed(1'b0, OP_OPSIZE, OP_OUT_B, 8'h00);
      send_directed(1'b1, OP_OPSIZE, OP_OUT_W, 8'h00);
      send_directed(1'b0, OP_OPSIZE, OP_OUT_W, 8'h00);
      send_directed(1'b0, OP_OPSIZE, OP_IN_B, 8'h00);
      send_directed(1'b0, OP_OPSIZE, OP_IN_W, 8'h00);
      send_directed(1'b1, OP_OPSIZE, OP_IN_W, 8'h00);
      send_directed(1'b1, OP_ADDRSIZE, OP_IN_B, 8'h00);
      send_directed(1'b0, OP_OPSIZE, OP_INT, VEC_SKIP);
      send_directed(1'b0, OP_OPSIZE, OP_INT, VEC_KERNEL_A);
      send_directed(1'b1, OP_ADDRSIZE, OP_INT, VEC_KERNEL_B);
      send_directed(1'b0, OP_OPSIZE, OP_INT, 8'h80);
      send_directed(1'b0, OP_OPSIZE, OP_CLI, 8'h00);
      send_directed(1'b1, OP_OPSIZE, OP_INT, 8'h13);
      send_directed(1'b0, OP_OPSIZE, OP_IRET, 8'h00);
      send_directed(1'b1, OP_OPSIZE, OP_IRET, 8'h00);
      send_directed(1'b0, OP_OPSIZE, OP_HLT, 8'h00);
      send_directed(1'b1, OP_ADDRSIZE, OP_HLT, 8'h00);
      send_directed(1'b0, OP_OPSIZE, OP_UNKNOWN, 8'h00);
      send_directed(1'b1, OP_OPSIZE, OP_OPSIZE, OP_PUSHF);
      wait_drained();

      write_flags_mask(32'hFFFF_FFFF);
      run_batch(BATCH_ITEMS, 1'b0, 1'b0, 1'b0);
      write_flags_mask(32'h0000_0000);
      run_batch(BATCH_ITEMS, 1'b1, 1'b1, 1'b0);
      rnd = $urandom;
      write_flags_mask(rnd);
      run_batch(BATCH_ITEMS, 1'b1, 1'b0, 1'b0);
      write_flags_mask(VALID_FLAGS_RESET);
      run_batch(BATCH_ITEMS, 1'b0, 1'b1, 1'b0);
      rnd = $urandom;
      write_flags_mask(rnd);
      run_batch(BATCH_ITEMS, 1'b1, 1'b1, 1'b1);

      repeat (4) @(posedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/v86sim_pkg.sv
rtl/v86_sensitive_instruction_monitor.sv
rtl/v86sim_checker.sv
bench/v86_emulation_checker.sv
bench/tb_top.sv
